// ----- src/bresenham_circle_rasterizer_defines.svh -----
// assertion macros shared by the rasterizer modules
`ifndef BRESENHAM_CIRCLE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_CIRCLE_RASTERIZER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define BCR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define BCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bcr_pkg.sv -----
package bcr_pkg;

  localparam int CoordBitsDefault = 10;
  localparam int InWidth          = 10;
  localparam int PixWidth         = 12;
  localparam int OffWidth         = 11;
  localparam int DecWidth         = 14;
  localparam int OctWidth         = 3;
  localparam int QueueDepth       = 2;

  typedef enum logic [0:0] {
    KindStart = 1'b0,
    KindStep  = 1'b1
  } kind_t;

  localparam logic [OctWidth-1:0] FirstOctant = 3'd0;
  localparam logic [OctWidth-1:0] LastOctant  = 3'd7;

  localparam logic [OctWidth-1:0] OctXpYp = 3'd0;
  localparam logic [OctWidth-1:0] OctYpXp = 3'd1;
  localparam logic [OctWidth-1:0] OctXmYp = 3'd2;
  localparam logic [OctWidth-1:0] OctYpXm = 3'd3;
  localparam logic [OctWidth-1:0] OctXpYm = 3'd4;
  localparam logic [OctWidth-1:0] OctYmXp = 3'd5;
  localparam logic [OctWidth-1:0] OctXmYm = 3'd6;
  localparam logic [OctWidth-1:0] OctYmXm = 3'd7;

  typedef struct packed {
    logic [InWidth-1:0]         cx;
    logic [InWidth-1:0]         cy;
    logic signed [OffWidth-1:0] x;
    logic signed [OffWidth-1:0] y;
    logic                       done;
  } point_t;

endpackage

// ----- src/bcr_in_if.sv -----
interface bcr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [bcr_pkg::InWidth-1:0]   center_x;
  logic [bcr_pkg::InWidth-1:0]   center_y;
  logic [bcr_pkg::InWidth-1:0]   radius;

  modport source (output valid, kind, center_x, center_y, radius, input ready);
  modport sink   (input valid, kind, center_x, center_y, radius, output ready);
endinterface

// ----- src/bcr_out_if.sv -----
interface bcr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bcr_pkg::PixWidth-1:0] pixel_x;
  logic signed [bcr_pkg::PixWidth-1:0] pixel_y;
  logic [bcr_pkg::OctWidth-1:0]        octant_index;
  logic                                last_of_point;
  logic                                circle_done;

  modport source (output valid, pixel_x, pixel_y, octant_index, last_of_point, circle_done,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, octant_index, last_of_point, circle_done,
                  output ready);
endinterface

// ----- src/bcr_fifo.sv -----
module bcr_fifo #(
  parameter int Depth = bcr_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bcr_pkg::point_t push_data,
  output logic            push_ready,
  input  logic            pop,
  output bcr_pkg::point_t head,
  output logic            head_valid
);
  import bcr_pkg::*;
  `include "bresenham_circle_rasterizer_defines.svh"

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(Depth - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(Depth);

  point_t             entries [Depth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [CntBits-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != FullCnt);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `BCR_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= FullCnt, "queue count past depth")
  `BCR_ASSERT_NOW(a_no_overflow, clk, rst, push, push_ready, "push into a full queue")

endmodule

// ----- src/bcr_front.sv -----
module bcr_front #(
  parameter int COORD_BITS = bcr_pkg::CoordBitsDefault
) (
  input  logic            clk,
  input  logic            rst,
  bcr_in_if.sink          cmd,
  output logic            push,
  output bcr_pkg::point_t push_data,
  input  logic            push_ready
);
  import bcr_pkg::*;
  `include "bresenham_circle_rasterizer_defines.svh"

  localparam int MaskBits = (COORD_BITS < InWidth) ? COORD_BITS : InWidth;
  localparam logic [InWidth-1:0] CoordMask = InWidth'((64'd1 << MaskBits) - 64'd1);

  logic [InWidth-1:0]         centre_x_reg;
  logic [InWidth-1:0]         centre_y_reg;
  logic signed [OffWidth-1:0] offset_x;
  logic signed [OffWidth-1:0] offset_y;
  logic signed [DecWidth-1:0] decision;
  logic                       active;

  logic                       accept;
  logic                       is_start;
  logic [InWidth-1:0]         r_m;
  logic signed [DecWidth-1:0] x_w;
  logic signed [DecWidth-1:0] y_w;
  logic signed [DecWidth-1:0] diff_w;
  logic signed [DecWidth-1:0] decision_next;
  logic signed [OffWidth-1:0] offset_x_next;
  logic signed [OffWidth-1:0] offset_y_next;
  logic [InWidth-1:0]         centre_x_next;
  logic [InWidth-1:0]         centre_y_next;
  logic                       done_next;

  assign cmd.ready = push_ready;
  assign accept    = cmd.valid && cmd.ready;
  assign is_start  = (cmd.kind == KindStart);
  assign r_m       = cmd.radius & CoordMask;

  assign x_w    = {{(DecWidth-OffWidth){offset_x[OffWidth-1]}}, offset_x};
  assign y_w    = {{(DecWidth-OffWidth){offset_y[OffWidth-1]}}, offset_y};
  assign diff_w = x_w - y_w;

  always_comb begin
    if (is_start) begin
      centre_x_next = cmd.center_x & CoordMask;
      centre_y_next = cmd.center_y & CoordMask;
      offset_x_next = '0;
      offset_y_next = $signed({{(OffWidth-InWidth){1'b0}}, r_m});
      decision_next = DecWidth'(3) - $signed({{(DecWidth-InWidth-1){1'b0}}, r_m, 1'b0});
    end else begin
      centre_x_next = centre_x_reg;
      centre_y_next = centre_y_reg;
      offset_x_next = offset_x + OffWidth'(1);
      if (decision <= 0) begin
        offset_y_next = offset_y;
        decision_next = decision + (x_w <<< 2) + DecWidth'(6);
      end else begin
        offset_y_next = offset_y - OffWidth'(1);
        decision_next = decision + (diff_w <<< 2) + DecWidth'(10);
      end
    end
  end

  assign done_next = (offset_x_next > offset_y_next);
  assign push      = accept && (is_start || active);

  always_comb begin
    push_data.cx   = centre_x_next;
    push_data.cy   = centre_y_next;
    push_data.x    = offset_x_next;
    push_data.y    = offset_y_next;
    push_data.done = done_next;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      centre_x_reg <= centre_x_next;
      centre_y_reg <= centre_y_next;
      offset_x     <= offset_x_next;
      offset_y     <= offset_y_next;
      decision     <= decision_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (push) begin
      active <= !done_next;
    end
  end

  `BCR_ASSERT_NEXT(a_done_ends_circle, clk, rst, push && push_data.done, !active,
                   "circle still active after its final point")

endmodule

// ----- src/bcr_back.sv -----
module bcr_back (
  input  logic            clk,
  input  logic            rst,
  input  bcr_pkg::point_t head,
  input  logic            head_valid,
  output logic            pop,
  bcr_out_if.source       pix
);
  import bcr_pkg::*;
  `include "bresenham_circle_rasterizer_defines.svh"

  logic [OctWidth-1:0]        k;
  logic                       load;
  logic signed [PixWidth-1:0] cx;
  logic signed [PixWidth-1:0] cy;
  logic signed [PixWidth-1:0] xs;
  logic signed [PixWidth-1:0] ys;
  logic signed [PixWidth-1:0] px;
  logic signed [PixWidth-1:0] py;

  assign load = head_valid && (!pix.valid || pix.ready);
  assign pop  = load && (k == LastOctant);

  assign cx = $signed({{(PixWidth-InWidth){1'b0}}, head.cx});
  assign cy = $signed({{(PixWidth-InWidth){1'b0}}, head.cy});
  assign xs = {{(PixWidth-OffWidth){head.x[OffWidth-1]}}, head.x};
  assign ys = {{(PixWidth-OffWidth){head.y[OffWidth-1]}}, head.y};

  always_comb begin
    case (k)
      OctXpYp: begin px = cx + xs; py = cy + ys; end
      OctYpXp: begin px = cx + ys; py = cy + xs; end
      OctXmYp: begin px = cx - xs; py = cy + ys; end
      OctYpXm: begin px = cx + ys; py = cy - xs; end
      OctXpYm: begin px = cx + xs; py = cy - ys; end
      OctYmXp: begin px = cx - ys; py = cy + xs; end
      OctXmYm: begin px = cx - xs; py = cy - ys; end
      default: begin px = cx - ys; py = cy - xs; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix.pixel_x       <= px;
      pix.pixel_y       <= py;
      pix.octant_index  <= k;
      pix.last_of_point <= (k == LastOctant);
      pix.circle_done   <= head.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= FirstOctant;
      pix.valid <= 1'b0;
    end else begin
      if (load) begin
        k         <= k + 1'b1;
        pix.valid <= 1'b1;
      end else if (pix.ready) begin
        pix.valid <= 1'b0;
      end
    end
  end

  `BCR_ASSERT_NOW(a_pop_after_eight, clk, rst, pop, head_valid && k == LastOctant,
                  "point released before its eighth pixel")
  `BCR_ASSERT_NEXT(a_word_order, clk, rst, load && k != LastOctant, k == $past(k) + 1'b1,
                   "pixel order skipped")

endmodule

// ----- src/bresenham_circle_rasterizer.sv -----
// Midpoint circle rasterizer with eight-way symmetry.
// cmd channel: one word per command. kind start loads centre and radius and
// plots the first octant point; kind step advances the decision term and plots
// the next point. A step with no circle in progress is taken and dropped.
// pix channel: eight words per plotted point, in octant order 0 to 7, the
// eighth with last_of_point set; circle_done marks all eight pixels of the
// final point, after which steps are dropped until the next start.
// Each point passes through the point queue and the pixel output register. Throughput:
// one pixel per cycle while pix is ready, so one command per eight pixels, set by
// the single pixel stage that walks the eight octants.
// A two-entry point queue sits between the command stage and the pixel stage,
// so commands keep flowing while earlier points drain.
// Reset (rst, synchronous) empties the queue and the output register and
// leaves no circle in progress.
// When pix stalls, the output word holds, the queue fills, then cmd.ready
// drops until room frees up.
module bresenham_circle_rasterizer #(
  parameter int COORD_BITS = bcr_pkg::CoordBitsDefault
) (
  input  logic      clk,
  input  logic      rst,
  bcr_in_if.sink    cmd,
  bcr_out_if.source pix
);
  import bcr_pkg::*;

  point_t push_data;
  point_t head;
  logic   push;
  logic   push_ready;
  logic   pop;
  logic   head_valid;

  bcr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  bcr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  bcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .pix        (pix)
  );

endmodule

// ----- sim/bcr_checker.sv -----
module bcr_checker
  import bcr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bcr_in_if    cmd,
  bcr_out_if   pix,
  output int   fail_count,
  output int   pending,
  output int   pixel_count,
  output int   circles_done
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [PixWidth-1:0] px;
    logic signed [PixWidth-1:0] py;
    logic [OctWidth-1:0]        oct;
    logic                       last;
    logic                       done;
  } pixel_t;

  pixel_t pending_pixels[$];

  // rasterizer state as the block should hold it
  logic signed [OffWidth-1:0] pt_x;
  logic signed [OffWidth-1:0] pt_y;
  logic signed [DecWidth-1:0] decision;
  logic [InWidth-1:0]         ctr_x;
  logic [InWidth-1:0]         ctr_y;
  logic                       drawing;

  initial begin
    fail_count   = 0;
    pending      = 0;
    pixel_count  = 0;
    circles_done = 0;
  end

  // eight mirrored pixels of the current octant point
  task automatic plot_point();
    int                  cxi;
    int                  cyi;
    int                  xi;
    int                  yi;
    int                  sx;
    int                  sy;
    logic                done;
    logic [OctWidth-1:0] oct;
    pixel_t              p;
    cxi  = int'(ctr_x);
    cyi  = int'(ctr_y);
    xi   = int'(pt_x);
    yi   = int'(pt_y);
    done = pt_x > pt_y;
    for (int k = 0; k < 8; k++) begin
      oct = OctWidth'(k);
      case (oct)
        OctXpYp: begin sx =  xi; sy =  yi; end
        OctYpXp: begin sx =  yi; sy =  xi; end
        OctXmYp: begin sx = -xi; sy =  yi; end
        OctYpXm: begin sx =  yi; sy = -xi; end
        OctXpYm: begin sx =  xi; sy = -yi; end
        OctYmXp: begin sx = -yi; sy =  xi; end
        OctXmYm: begin sx = -xi; sy = -yi; end
        default: begin sx = -yi; sy = -xi; end
      endcase
      p.px   = PixWidth'(cxi + sx);
      p.py   = PixWidth'(cyi + sy);
      p.oct  = oct;
      p.last = (oct == LastOctant);
      p.done = done;
      pending_pixels.push_back(p);
    end
    if (done) drawing = 1'b0;
  endtask

  task automatic take_command();
    if (kind_t'(cmd.kind) == KindStart) begin
      ctr_x    = cmd.center_x;
      ctr_y    = cmd.center_y;
      pt_x     = '0;
      pt_y     = {1'b0, cmd.radius};
      decision = DecWidth'(3 - 2 * int'(cmd.radius));
      drawing  = 1'b1;
      plot_point();
    end else if (drawing) begin
      if (decision <= 0) begin
        decision = DecWidth'(decision + 4 * pt_x + 6);
        pt_x     = OffWidth'(pt_x + 1);
      end else begin
        decision = DecWidth'(decision + 4 * (pt_x - pt_y) + 10);
        pt_x     = OffWidth'(pt_x + 1);
        pt_y     = OffWidth'(pt_y - 1);
      end
      plot_point();
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      $error("pixel word (%0d, %0d) arrived with nothing expected",
             pix.pixel_x, pix.pixel_y);
      fail_count++;
    end else begin
      want = pending_pixels.pop_front();
      check_field("pixel_x", want.px, pix.pixel_x);
      check_field("pixel_y", want.py, pix.pixel_y);
      check_field("octant_index", want.oct, pix.octant_index);
      check_field("last_of_point", want.last, pix.last_of_point);
      check_field("circle_done", want.done, pix.circle_done);
      pixel_count++;
      if (want.done && want.last) circles_done++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pt_x     = '0;
      pt_y     = '0;
      decision = '0;
      ctr_x    = '0;
      ctr_y    = '0;
      drawing  = 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) take_command();
      if (pix.valid && pix.ready) check_pixel();
    end
    pending = pending_pixels.size();
  end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcr_pkg::*;

  localparam longint CycleLimit = 300000;
  localparam int     HoldCycles = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bcr_in_if  cmd_if ();
  bcr_out_if pix_if ();

  int  fail_count;
  int  pending;
  int  pixel_count;
  int  circles_done;

  bit     hold_req    = 1'b0;
  bit     gaps_on     = 1'b1;
  int     burst_left  = 0;
  int     word_count  = 0;
  int     start_count = 0;
  longint cycles      = 0;

  bresenham_circle_rasterizer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .pix (pix_if)
  );

  bcr_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd_if),
    .pix          (pix_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .pixel_count  (pixel_count),
    .circles_done (circles_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("run exceeded %0d cycles", CycleLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(kind_t k, input logic [InWidth-1:0] cx, cy, r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = gaps_on ? $urandom_range(1, 8) : 0;
      repeat (gap) begin
        @(negedge clk);
        cmd_if.valid    = 1'b0;
        cmd_if.kind     = 1'($urandom_range(0, 1));
        cmd_if.center_x = InWidth'($urandom);
        cmd_if.center_y = InWidth'($urandom);
        cmd_if.radius   = InWidth'($urandom);
      end
    end
    burst_left--;
    @(negedge clk);
    cmd_if.valid    = 1'b1;
    cmd_if.kind     = k;
    cmd_if.center_x = cx;
    cmd_if.center_y = cy;
    cmd_if.radius   = r;
    do @(posedge clk); while (!cmd_if.ready);
    word_count++;
    if (k == KindStart) start_count++;
  endtask

  task automatic send_circle(input logic [InWidth-1:0] cx, cy, r, input int steps);
    send_word(KindStart, cx, cy, r);
    repeat (steps) begin
      send_word(KindStep, InWidth'($urandom), InWidth'($urandom), InWidth'($urandom));
    end
  endtask

  // receiver ready pattern, with one long hold-off
  initial begin : rx
    int hold_left;
    int mode;
    int phase_left;
    hold_left    = 0;
    mode         = 0;
    phase_left   = 0;
    pix_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 2);
        phase_left = $urandom_range(50, 300);
      end else begin
        phase_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_if.ready = 1'b0;
      end else begin
        case (mode)
          0:       pix_if.ready = 1'b1;
          1:       pix_if.ready = 1'($urandom_range(0, 1));
          default: pix_if.ready = (phase_left % 5) < 3;
        endcase
      end
    end
  end

  initial begin : stim
    int sel;
    int r;
    int est;
    int steps;
    int planned;
    cmd_if.valid    = 1'b0;
    cmd_if.kind     = KindStep;
    cmd_if.center_x = '0;
    cmd_if.center_y = '0;
    cmd_if.radius   = '0;
    planned         = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // step with no circle in progress
    send_word(KindStep, 10'h3ff, 10'h3ff, 10'h3ff);
    // zero radius, then a step past the final point
    send_circle(10'd0, 10'd0, 10'd0, 3);
    send_circle(10'h3ff, 10'h3ff, 10'h3ff, 3);
    // restart while the previous circle is still open
    send_circle(10'd0, 10'd0, 10'h3ff, 2);
    send_circle(10'd512, 10'd512, 10'd1, 3);
    send_circle(10'd5, 10'd1000, 10'd2, 3);
    send_circle(10'h3ff, 10'd0, 10'd3, 4);

    // back up the point queue until cmd stalls
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    send_circle(10'd300, 10'd700, 10'd30, 24);
    gaps_on  = 1'b1;

    while (planned < 500) begin
      sel     = $urandom_range(0, 9);
      gaps_on = $urandom_range(0, 3) != 0;
      if (sel < 8) begin
        if ($urandom_range(0, 19) == 0) r = $urandom_range(0, 1023);
        else if ($urandom_range(0, 9) == 0) r = $urandom_range(41, 200);
        else r = $urandom_range(0, 40);
        est = r * 3 / 4 + 2;
        if (est > 40) est = 40;
        steps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, est) : est;
        send_circle(InWidth'($urandom_range(0, 1023)), InWidth'($urandom_range(0, 1023)),
                    InWidth'(r), steps);
        planned += 1 + steps;
      end else if (sel == 8) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(KindStep, InWidth'($urandom), InWidth'($urandom), InWidth'($urandom));
        end
      end else begin
        send_circle(InWidth'($urandom), InWidth'($urandom), InWidth'($urandom),
                    $urandom_range(0, 3));
      end
    end

    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("%0d command words (%0d starts), %0d pixels checked, %0d circles closed",
             word_count, start_count, pixel_count, circles_done);
    $display("one %0d-cycle receiver hold-off, random bursts and stalls on both sides",
             HoldCycles);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
